>>> rtl/interior_penalty_face_flux_top_defines.svh
// assertion macros for the face flux block
`ifndef INTERIOR_PENALTY_FACE_FLUX_TOP_DEFINES_SVH
`define INTERIOR_PENALTY_FACE_FLUX_TOP_DEFINES_SVH

// checked outside reset
`define IPFF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define IPFF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/ipff_pkg.sv
package ipff_pkg;

  localparam int DATA_W    = 48;
  localparam int UVAL_W    = 47;
  localparam int SUM_W     = 54;
  localparam int ACC_W     = 112;
  localparam int MUL_A_W   = 56;
  localparam int DIG_W     = 16;
  localparam int PP_W      = MUL_A_W + DIG_W;
  localparam int DIV_W     = 110;
  localparam int DEN_W     = 53;
  localparam int REM_W     = DEN_W + 1;
  localparam int FRAC_BITS = 32;
  localparam int MAX_GAUSS = 16;
  localparam int PT_AW     = 4;
  localparam int CNT_W     = 5;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;

  localparam logic [2:0] DIG_LAST_S = 3'd2;
  localparam logic [2:0] DIG_LAST_L = 3'd6;
  localparam logic [6:0] DIV_LAST   = 7'(DIV_W - 1);

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic [46:0] SCALE_RST = 47'h1_0000_0000;
  localparam logic [3:0]  ORDER_RST = 4'd1;
  localparam logic [4:0]  GAUSS_RST = 5'd4;

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_MINUS  = 2'd1,
    ACT_PLUS   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_ORDER = 2'd1,
    REG_GAUSS = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_ITEM,
    ST_HDIV,
    ST_HFIN,
    ST_M1,
    ST_M2,
    ST_QDIV,
    ST_PEN,
    ST_RD,
    ST_LD,
    ST_FN,
    ST_FNR,
    ST_FX,
    ST_FXR
  } state_e;

endpackage

>>> rtl/interior_penalty_face_flux_top.sv
// channel   direction  handshake                      payload
// item      in         start high and busy low        action_i, vec_*_i, unknown, volumes
// result    out        result_valid_o, one cycle      flux_*_o, normal_flux_o, face_done_o
// config    in         apb write, pready always high  penalty_scale, poly_order, gauss_per_face
//
// a minus or plus item keeps busy high while nine 56x16 partial products
// on the shared multiplier form the dot product with the normal
// the last plus item of a face adds two 110-step restoring divides and the penalty
// products, and then emits each gauss point out of the point memory
// a header does not raise busy; reset loads the register defaults and clears header state
// results cannot be held off; each point is shown for one cycle
`include "interior_penalty_face_flux_top_defines.svh"

module interior_penalty_face_flux_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic signed [47:0]            vec_x_i,
  input  logic signed [47:0]            vec_y_i,
  input  logic signed [47:0]            vec_z_i,
  input  logic signed [47:0]            unknown_value_i,
  input  logic signed [47:0]            diffusivity_i,
  input  logic [46:0]                   owner_volume_i,
  input  logic [46:0]                   neighbour_volume_i,
  input  logic [46:0]                   face_area_i,
  input  logic                          is_internal_i,
  input  logic                          copy_minus_flux_i,
  output logic                          result_valid_o,
  output logic signed [47:0]            flux_x_o,
  output logic signed [47:0]            flux_y_o,
  output logic signed [47:0]            flux_z_o,
  output logic signed [47:0]            normal_flux_o,
  output logic                          face_done_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipff_pkg::PADDR_W-1:0]  paddr,
  input  logic [ipff_pkg::PDATA_W-1:0]  pwdata,
  output logic [ipff_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ipff_pkg::*;

  function automatic logic [DATA_W-1:0] mag48(input logic [DATA_W-1:0] v);
    mag48 = v[DATA_W-1] ? (~v + 48'd1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] rnd_sat(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] t;
    t = v + ROUND_HALF;
    if ((&t[ACC_W-1:79]) || !(|t[ACC_W-1:79])) begin
      rnd_sat = t[79:32];
    end else begin
      rnd_sat = t[ACC_W-1] ? DATA_MIN : DATA_MAX;
    end
  endfunction

  // configuration
  logic [46:0] scale_q;
  logic [3:0]  order_q;
  logic [4:0]  gauss_q;
  logic [4:0]  n_eff;
  logic        cfg_we;

  // face state
  logic [DATA_W-1:0] nrm_q [3];
  logic [DATA_W-1:0] nrm_d [3];
  logic [46:0]       vmin_q, vmin_d, area_q, area_d;
  logic              bcopy_q, bcopy_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DATA_W-1:0] mh_dot_q, mh_dot_d, mh_u_q, mh_u_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // item payload
  logic [DATA_W-1:0] f_q [3];
  logic [DATA_W-1:0] f_d [3];
  logic [DATA_W-1:0] u_q, u_d, d_q, d_d;
  logic              plus_q, plus_d;

  // sequencer and datapath
  state_e            state_q, state_d;
  logic [1:0]        comp_q, comp_d;
  logic [2:0]        dig_q, dig_d;
  logic [ACC_W-1:0]  acc_q, acc_d, mb_q, mb_d;
  logic [DIV_W-1:0]  dn_q, dn_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [6:0]        dbit_q, dbit_d;
  logic [DATA_W-1:0] pen_q, pen_d, fn_q, fn_d;
  logic [DATA_W-1:0] flux_q [3];
  logic [DATA_W-1:0] flux_d [3];
  logic [PT_AW-1:0]  k_q, k_d;
  logic              valid_q, valid_d, done_q, done_d;

  // point memory: central and jump
  logic [2*DATA_W-1:0] pt_mem [MAX_GAUSS];
  logic [2*DATA_W-1:0] rd_q, mem_wdata;
  logic                mem_we;
  logic [DATA_W-1:0]   central_rd, jump_rd;

  logic accept;
  logic [MUL_A_W-1:0] mac_a;
  logic [ACC_W-1:0]   mac_b, sh, mac_sum;
  logic               mac_neg;
  logic [DIG_W-1:0]   digit;
  logic [PP_W-1:0]    pp;
  logic [SUM_W-1:0]   sum_mag;
  logic [4:0]         p1;
  logic [9:0]         p1sq;
  logic [REM_W-1:0]   rem_sh;
  logic               div_ge;
  logic               pt_last;

  assign accept     = start && !busy;
  assign busy       = (state_q != ST_IDLE);
  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign central_rd = rd_q[2*DATA_W-1:DATA_W];
  assign jump_rd    = rd_q[DATA_W-1:0];
  assign sum_mag    = sum_q[SUM_W-1] ? (~sum_q + 54'd1) : sum_q;
  assign p1         = {1'b0, order_q} + 5'd1;
  assign p1sq       = 10'(p1) * 10'(p1);
  assign pt_last    = (({1'b0, k_q} + 5'd1) == n_eff);

  always_comb begin
    if (gauss_q == 5'd0) begin
      n_eff = 5'd1;
    end else if (gauss_q > 5'(MAX_GAUSS)) begin
      n_eff = 5'(MAX_GAUSS);
    end else begin
      n_eff = gauss_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      order_q <= ORDER_RST;
      gauss_q <= GAUSS_RST;
    end else if (cfg_we) begin
      unique case (paddr[4:3])
        REG_SCALE: scale_q <= pwdata[46:0];
        REG_ORDER: order_q <= pwdata[3:0];
        REG_GAUSS: gauss_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SCALE: prdata = {17'b0, scale_q};
      REG_ORDER: prdata = {60'b0, order_q};
      REG_GAUSS: prdata = {59'b0, gauss_q};
      default:   prdata = '0;
    endcase
  end

  // shared multiply-accumulate, one 16-bit digit of b per cycle
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_neg = 1'b0;
    unique case (state_q)
      ST_DOT: begin
        mac_a   = {8'b0, mag48(f_q[comp_q])};
        mac_b   = {64'b0, mag48(nrm_q[comp_q])};
        mac_neg = f_q[comp_q][DATA_W-1] ^ nrm_q[comp_q][DATA_W-1];
      end
      ST_M1: begin
        mac_a = {2'b0, sum_mag};
        mac_b = {65'b0, scale_q};
      end
      ST_M2: begin
        mac_a = {46'b0, p1sq};
        mac_b = mb_q;
      end
      ST_FN: begin
        mac_a   = {8'b0, mag48(pen_q)};
        mac_b   = {64'b0, mag48(jump_rd)};
        mac_neg = !(pen_q[DATA_W-1] ^ jump_rd[DATA_W-1]);
      end
      ST_FX: begin
        mac_a   = {8'b0, mag48(fn_q)};
        mac_b   = {64'b0, mag48(nrm_q[comp_q])};
        mac_neg = fn_q[DATA_W-1] ^ nrm_q[comp_q][DATA_W-1];
      end
      default: ;
    endcase
  end

  assign digit   = mac_b[{dig_q, 4'b0000} +: DIG_W];
  assign pp      = mac_a * digit;
  assign sh      = ACC_W'(pp) << {dig_q, 4'b0000};
  assign mac_sum = mac_neg ? (acc_q - sh) : (acc_q + sh);

  // restoring divider step
  assign rem_sh = {rem_q[REM_W-2:0], dn_q[DIV_W-1]};
  assign div_ge = (rem_sh >= {1'b0, den_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_MINUS || action_i == ACT_PLUS)) state_d = ST_DOT;
      end
      ST_DOT: if (dig_q == DIG_LAST_S && comp_q == 2'd2) state_d = ST_ITEM;
      ST_ITEM: begin
        if (plus_q && ((cnt_q + 5'd1) >= n_eff)) state_d = ST_HDIV;
        else state_d = ST_IDLE;
      end
      ST_HDIV: if (dbit_q == DIV_LAST) state_d = ST_HFIN;
      ST_HFIN: state_d = ST_M1;
      ST_M1:   if (dig_q == DIG_LAST_S) state_d = ST_M2;
      ST_M2:   if (dig_q == DIG_LAST_L) state_d = ST_QDIV;
      ST_QDIV: if (dbit_q == DIV_LAST) state_d = ST_PEN;
      ST_PEN:  state_d = ST_RD;
      ST_RD:   state_d = ST_LD;
      ST_LD:   state_d = ST_FN;
      ST_FN:   if (dig_q == DIG_LAST_S) state_d = ST_FNR;
      ST_FNR:  state_d = ST_FX;
      ST_FX:   if (dig_q == DIG_LAST_S) state_d = ST_FXR;
      ST_FXR: begin
        if (comp_q == 2'd2) state_d = pt_last ? ST_IDLE : ST_RD;
        else state_d = ST_FX;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    logic [DATA_W-1:0] dot, fr, jump, central;
    logic [DATA_W:0]   cs, js;
    logic [SUM_W:0]    ss;
    logic [46:0]       vn, h;
    logic [DIV_W-1:0]  q;

    nrm_d     = nrm_q;
    vmin_d    = vmin_q;
    area_d    = area_q;
    bcopy_d   = bcopy_q;
    sum_d     = sum_q;
    mh_dot_d  = mh_dot_q;
    mh_u_d    = mh_u_q;
    cnt_d     = cnt_q;
    f_d       = f_q;
    u_d       = u_q;
    d_d       = d_q;
    plus_d    = plus_q;
    comp_d    = comp_q;
    dig_d     = dig_q;
    acc_d     = acc_q;
    mb_d      = mb_q;
    dn_d      = dn_q;
    rem_d     = rem_q;
    den_d     = den_q;
    dbit_d    = dbit_q;
    pen_d     = pen_q;
    fn_d      = fn_q;
    flux_d    = flux_q;
    k_d       = k_q;
    valid_d   = 1'b0;
    done_d    = done_q;
    mem_we    = 1'b0;
    mem_wdata = '0;

    dot     = rnd_sat(acc_q);
    fr      = bcopy_q ? mh_dot_q : dot;
    cs      = {mh_dot_q[DATA_W-1], mh_dot_q} + {fr[DATA_W-1], fr} + 49'd1;
    central = cs[DATA_W:1];
    js      = {u_q[DATA_W-1], u_q} - {mh_u_q[DATA_W-1], mh_u_q};
    jump    = (js[DATA_W] == js[DATA_W-1]) ? js[DATA_W-1:0] :
              (js[DATA_W] ? DATA_MIN : DATA_MAX);
    ss      = {sum_q[SUM_W-1], sum_q} + {{7{d_q[DATA_W-1]}}, d_q};
    vn      = (is_internal_i && (neighbour_volume_i < owner_volume_i)) ?
              neighbour_volume_i : owner_volume_i;
    q       = dn_q;
    if (|q[DIV_W-1:47]) begin
      h = '1;
    end else if (q[46:0] == 47'd0) begin
      h = 47'd1;
    end else begin
      h = q[46:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_HEADER: begin
              nrm_d[0] = vec_x_i;
              nrm_d[1] = vec_y_i;
              nrm_d[2] = vec_z_i;
              vmin_d   = vn;
              area_d   = (face_area_i == 47'd0) ? 47'd1 : face_area_i;
              bcopy_d  = copy_minus_flux_i;
              sum_d    = '0;
              mh_dot_d = '0;
              mh_u_d   = '0;
              cnt_d    = '0;
            end
            ACT_MINUS, ACT_PLUS: begin
              f_d[0] = vec_x_i;
              f_d[1] = vec_y_i;
              f_d[2] = vec_z_i;
              u_d    = unknown_value_i;
              d_d    = diffusivity_i;
              plus_d = (action_i == ACT_PLUS);
              acc_d  = '0;
              dig_d  = '0;
              comp_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DOT, ST_FX: begin
        acc_d = mac_sum;
        if (dig_q == DIG_LAST_S) begin
          dig_d = '0;
          if (state_q == ST_DOT) comp_d = comp_q + 2'd1;
        end else begin
          dig_d = dig_q + 3'd1;
        end
      end
      ST_ITEM: begin
        sum_d = (ss[SUM_W] == ss[SUM_W-1]) ? ss[SUM_W-1:0] :
                (ss[SUM_W] ? SUM_MIN : SUM_MAX);
        if (!plus_q) begin
          mh_dot_d = dot;
          mh_u_d   = u_q;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {central, jump};
          cnt_d     = cnt_q + 5'd1;
          dn_d      = {31'b0, vmin_q, 32'b0};
          rem_d     = '0;
          dbit_d    = '0;
          den_d     = {6'b0, area_q};
        end
      end
      ST_HDIV, ST_QDIV: begin
        rem_d  = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        dn_d   = {dn_q[DIV_W-2:0], div_ge};
        dbit_d = dbit_q + 7'd1;
      end
      ST_HFIN: begin
        den_d = DEN_W'(h) * DEN_W'({n_eff, 1'b0});
        acc_d = '0;
        dig_d = '0;
      end
      ST_M1: begin
        acc_d = mac_sum;
        dig_d = dig_q + 3'd1;
        if (dig_q == DIG_LAST_S) begin
          mb_d  = mac_sum;
          acc_d = '0;
          dig_d = '0;
        end
      end
      ST_M2: begin
        acc_d = mac_sum;
        dig_d = dig_q + 3'd1;
        if (dig_q == DIG_LAST_L) begin
          dn_d   = mac_sum[DIV_W-1:0];
          rem_d  = '0;
          dbit_d = '0;
        end
      end
      ST_PEN: begin
        if (sum_q[SUM_W-1]) begin
          pen_d = (|q[DIV_W-1:47]) ? DATA_MIN : (~q[DATA_W-1:0] + 48'd1);
        end else begin
          pen_d = (|q[DIV_W-1:47]) ? DATA_MAX : q[DATA_W-1:0];
        end
        k_d = '0;
      end
      ST_RD: ;
      ST_LD: begin
        acc_d = {{32{central_rd[DATA_W-1]}}, central_rd, 32'b0};
        dig_d = '0;
      end
      ST_FN: begin
        acc_d = mac_sum;
        dig_d = (dig_q == DIG_LAST_S) ? 3'd0 : (dig_q + 3'd1);
      end
      ST_FNR: begin
        fn_d   = dot;
        acc_d  = '0;
        comp_d = '0;
        dig_d  = '0;
      end
      ST_FXR: begin
        flux_d[comp_q] = dot;
        acc_d          = '0;
        if (comp_q == 2'd2) begin
          valid_d = 1'b1;
          done_d  = pt_last;
          comp_d  = '0;
          if (pt_last) begin
            cnt_d = '0;
            sum_d = '0;
          end else begin
            k_d = k_q + 4'd1;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nrm_q    <= '{default: '0};
      vmin_q   <= '0;
      area_q   <= '0;
      bcopy_q  <= 1'b0;
      sum_q    <= '0;
      mh_dot_q <= '0;
      mh_u_q   <= '0;
      cnt_q    <= '0;
      comp_q   <= '0;
      dig_q    <= '0;
      dbit_q   <= '0;
      k_q      <= '0;
      valid_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      nrm_q    <= nrm_d;
      vmin_q   <= vmin_d;
      area_q   <= area_d;
      bcopy_q  <= bcopy_d;
      sum_q    <= sum_d;
      mh_dot_q <= mh_dot_d;
      mh_u_q   <= mh_u_d;
      cnt_q    <= cnt_d;
      comp_q   <= comp_d;
      dig_q    <= dig_d;
      dbit_q   <= dbit_d;
      k_q      <= k_d;
      valid_q  <= valid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    u_q    <= u_d;
    d_q    <= d_d;
    plus_q <= plus_d;
    acc_q  <= acc_d;
    mb_q   <= mb_d;
    dn_q   <= dn_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    pen_q  <= pen_d;
    fn_q   <= fn_d;
    flux_q <= flux_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pt_mem[cnt_q[PT_AW-1:0]] <= mem_wdata;
    end
    if (state_q == ST_RD) begin
      rd_q <= pt_mem[k_q];
    end
  end

  assign result_valid_o = valid_q;
  assign face_done_o    = done_q;
  assign flux_x_o       = flux_q[0];
  assign flux_y_o       = flux_q[1];
  assign flux_z_o       = flux_q[2];
  assign normal_flux_o  = fn_q;

  `IPFF_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "result strobe longer than one cycle")
  `IPFF_ASSERT(a_done_idle, (result_valid_o && face_done_o) |-> !busy, "busy after last point")
  `IPFF_ASSERT(a_mid_busy, (result_valid_o && !face_done_o) |-> busy, "idle in mid emission")
  `IPFF_ASSERT(a_cnt_range, cnt_q <= 5'(MAX_GAUSS), "point count out of range")
  `IPFF_ASSERT(a_hdr_clear, (accept && action_i == ACT_HEADER) |=> (cnt_q == 5'd0), "header kept count")
  `IPFF_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !result_valid_o, "result during reset")

endmodule

>>> verif/interior_penalty_face_flux_top_tb.sv
module interior_penalty_face_flux_top_tb;
  import ipff_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_ITEMS = 47;

  typedef logic signed [255:0] wide_t;
  localparam wide_t MAX48 = (wide_t'(1) <<< 47) - 1;
  localparam wide_t MIN48 = -(wide_t'(1) <<< 47);
  localparam wide_t MAX54 = (wide_t'(1) <<< 53) - 1;
  localparam wide_t MIN54 = -(wide_t'(1) <<< 53);
  localparam logic signed [47:0] S_MAX = DATA_MAX;
  localparam logic signed [47:0] S_MIN = DATA_MIN;
  localparam logic signed [47:0] ONE = 48'sh1_0000_0000;
  localparam logic [46:0] U_MAX = {47{1'b1}};

  typedef struct {
    logic [1:0] action;
    logic signed [47:0] vx, vy, vz, u, d;
    logic [46:0] vo, vn, area;
    logic internal, copy;
    bit zero_exp;
  } item_t;

  typedef struct {
    logic signed [47:0] fx, fy, fz, fn;
    logic done;
  } flux_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic signed [47:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [47:0] unknown_value_i = '0, diffusivity_i = '0;
  logic [46:0] owner_volume_i = '0, neighbour_volume_i = '0, face_area_i = '0;
  logic is_internal_i = 1'b0, copy_minus_flux_i = 1'b0;
  logic result_valid_o;
  logic signed [47:0] flux_x_o, flux_y_o, flux_z_o, normal_flux_o;
  logic face_done_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  interior_penalty_face_flux_top uut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .vec_x_i, .vec_y_i, .vec_z_i,
    .unknown_value_i, .diffusivity_i, .owner_volume_i, .neighbour_volume_i,
    .face_area_i, .is_internal_i, .copy_minus_flux_i, .result_valid_o,
    .flux_x_o, .flux_y_o, .flux_z_o, .normal_flux_o, .face_done_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [46:0] m_scale;
  logic [3:0] m_order;
  logic [4:0] m_gauss;
  logic signed [47:0] m_normal [3];
  logic [46:0] m_small_vol, m_area;
  logic m_copy;
  wide_t m_dsum;
  logic signed [47:0] m_central [MAX_GAUSS];
  logic signed [47:0] m_jump [MAX_GAUSS];
  logic signed [47:0] m_minus_fn, m_minus_u;
  int m_count;

  flux_t expected_flux [$];
  int fails = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit idling_on = 1'b1;

  function automatic logic signed [47:0] sat48(wide_t v);
    if (v > MAX48) return S_MAX;
    if (v < MIN48) return S_MIN;
    return v[47:0];
  endfunction

  function automatic wide_t round_shift(wide_t v, int s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [47:0] dot_normal(item_t it);
    wide_t t;
    t = wide_t'(it.vx) * wide_t'(m_normal[0]) + wide_t'(it.vy) * wide_t'(m_normal[1])
      + wide_t'(it.vz) * wide_t'(m_normal[2]);
    return sat48(round_shift(t, 32));
  endfunction

  function automatic void add_diffusivity(logic signed [47:0] d);
    m_dsum = m_dsum + wide_t'(d);
    if (m_dsum > MAX54) m_dsum = MAX54;
    if (m_dsum < MIN54) m_dsum = MIN54;
  endfunction

  function automatic int gauss_count();
    if (m_gauss == 0) return 1;
    if (m_gauss > MAX_GAUSS) return MAX_GAUSS;
    return int'(m_gauss);
  endfunction

  function automatic void emit_face(int n, bit zero_exp);
    wide_t h, m, q, t, p1;
    logic signed [47:0] penalty, fn;
    flux_t r;
    bit neg;
    h = (wide_t'(m_small_vol) <<< 32) / wide_t'(m_area);
    if (h > MAX48) h = MAX48;
    else if (h == 0) h = 1;
    neg = m_dsum < 0;
    p1 = wide_t'(m_order) + 1;
    m = (neg ? -m_dsum : m_dsum) * wide_t'(m_scale) * (p1 * p1);
    q = (m / h) / wide_t'(2 * n);
    penalty = sat48(neg ? -q : q);
    for (int k = 0; k < n; k++) begin
      t = (wide_t'(m_central[k]) <<< 32) - wide_t'(penalty) * wide_t'(m_jump[k]);
      fn = sat48(round_shift(t, 32));
      r.fx = sat48(round_shift(wide_t'(fn) * wide_t'(m_normal[0]), 32));
      r.fy = sat48(round_shift(wide_t'(fn) * wide_t'(m_normal[1]), 32));
      r.fz = sat48(round_shift(wide_t'(fn) * wide_t'(m_normal[2]), 32));
      r.fn = fn;
      r.done = (k == n - 1);
      if (zero_exp) begin
        r.fx = '0; r.fy = '0; r.fz = '0; r.fn = '0;
      end
      expected_flux.push_back(r);
    end
    m_count = 0;
    m_dsum = 0;
  endfunction

  function automatic void predict_item(item_t it);
    int n;
    logic signed [47:0] fr;
    n = gauss_count();
    if (it.action == ACT_HEADER) begin
      m_normal[0] = it.vx; m_normal[1] = it.vy; m_normal[2] = it.vz;
      m_small_vol = it.vo;
      if (it.internal && it.vn < it.vo) m_small_vol = it.vn;
      m_area = (it.area == 0) ? 47'd1 : it.area;
      m_copy = it.copy;
      m_dsum = 0;
      m_minus_fn = '0;
      m_minus_u = '0;
      m_count = 0;
    end else if (it.action == ACT_MINUS) begin
      m_minus_fn = dot_normal(it);
      m_minus_u = it.u;
      add_diffusivity(it.d);
    end else if (it.action == ACT_PLUS) begin
      fr = m_copy ? m_minus_fn : dot_normal(it);
      m_central[m_count] = sat48(round_shift(wide_t'(m_minus_fn) + wide_t'(fr), 1));
      m_jump[m_count] = sat48(wide_t'(it.u) - wide_t'(m_minus_u));
      add_diffusivity(it.d);
      m_count++;
      if (m_count >= n) emit_face(n, it.zero_exp);
    end
  endfunction

  // results
  always @(posedge clk_i) begin
    flux_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_flux.size() == 0) begin
        fails++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result fn=%h", normal_flux_o);
      end else begin
        e = expected_flux.pop_front();
        if (flux_x_o !== e.fx || flux_y_o !== e.fy || flux_z_o !== e.fz ||
            normal_flux_o !== e.fn || face_done_o !== e.done) begin
          fails++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                     e.fx, e.fy, e.fz, e.fn, e.done,
                     flux_x_o, flux_y_o, flux_z_o, normal_flux_o, face_done_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("interior_penalty_face_flux_top_tb failed");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    action_i = it.action;
    vec_x_i = it.vx; vec_y_i = it.vy; vec_z_i = it.vz;
    unknown_value_i = it.u; diffusivity_i = it.d;
    owner_volume_i = it.vo; neighbour_volume_i = it.vn; face_area_i = it.area;
    is_internal_i = it.internal; copy_minus_flux_i = it.copy;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_item(it);
  endtask

  task automatic write_reg(reg_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = PADDR_W'(int'(idx) * 8);
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SCALE: m_scale = value[46:0];
      REG_ORDER: m_order = value[3:0];
      default: m_gauss = value[4:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_flux.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic signed [47:0] rnd_val(int lo_sh, int hi_sh);
    logic signed [63:0] r;
    r = $signed({$urandom, $urandom});
    case ($urandom_range(0, 11))
      0: return r[47:0];
      1: return S_MAX;
      2: return S_MIN;
      default: return 48'(r >>> $urandom_range(lo_sh, hi_sh));
    endcase
  endfunction

  function automatic logic [46:0] rnd_uval(int lo_sh, int hi_sh);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: return r[46:0];
      1: return U_MAX;
      2: return '0;
      default: return 47'(r >> $urandom_range(lo_sh, hi_sh));
    endcase
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.action = 2'($urandom);
    it.vx = 48'({$urandom, $urandom}); it.vy = 48'({$urandom, $urandom});
    it.vz = 48'({$urandom, $urandom}); it.u = 48'({$urandom, $urandom});
    it.d = 48'({$urandom, $urandom});
    it.vo = 47'({$urandom, $urandom}); it.vn = 47'({$urandom, $urandom});
    it.area = 47'({$urandom, $urandom});
    it.internal = $urandom; it.copy = $urandom;
    it.zero_exp = 1'b0;
    return it;
  endfunction

  function automatic item_t header_item();
    item_t it;
    it = noise_item();
    it.action = ACT_HEADER;
    it.vx = rnd_val(29, 33); it.vy = rnd_val(29, 33); it.vz = rnd_val(29, 33);
    it.vo = rnd_uval(27, 34); it.vn = rnd_uval(27, 34); it.area = rnd_uval(29, 36);
    it.copy = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic item_t point_item(logic [1:0] act);
    item_t it;
    it = noise_item();
    it.action = act;
    it.vx = rnd_val(26, 40); it.vy = rnd_val(26, 40); it.vz = rnd_val(26, 40);
    it.u = rnd_val(26, 40); it.d = rnd_val(28, 40);
    return it;
  endfunction

  function automatic item_t mk(logic [1:0] a, logic signed [47:0] vx, vy, vz, u, d,
                               logic [46:0] vo, vn, area, logic internal, copy,
                               bit zero_exp);
    item_t it;
    it.action = a; it.vx = vx; it.vy = vy; it.vz = vz; it.u = u; it.d = d;
    it.vo = vo; it.vn = vn; it.area = area; it.internal = internal; it.copy = copy;
    it.zero_exp = zero_exp;
    return it;
  endfunction

  item_t directed [$];
  logic [63:0] phase_scale [7];
  logic [3:0] phase_order [7];
  logic [4:0] phase_gauss [7];

  initial begin
    int counted;
    int n;
    int pick;
    m_scale = SCALE_RST; m_order = ORDER_RST; m_gauss = GAUSS_RST;
    m_normal = '{default: '0};
    m_small_vol = '0; m_area = '0; m_copy = 1'b0; m_dsum = 0;
    m_minus_fn = '0; m_minus_u = '0; m_count = 0;

    // zero normal with equal unknowns gives all-zero flux
    directed.push_back(mk(ACT_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(mk(ACT_MINUS, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, -ONE, ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 1));
    // extreme header, plus without minus, unused action, repeated minus
    directed.push_back(mk(ACT_HEADER, S_MAX, S_MIN, ONE, 0, 0, U_MAX, U_MAX, U_MAX, 1, 0, 0));
    directed.push_back(mk(ACT_PLUS, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_UNUSED, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, ONE, 0, 0, -ONE, S_MAX, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, 0, ONE, 0, ONE, S_MAX, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, ONE, ONE, 0, S_MAX, S_MIN, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, ONE, 0, ONE, S_MIN, S_MIN, 0, 0, 0, 0, 0, 0));
    // physical boundary
    directed.push_back(mk(ACT_HEADER, ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, 1, 0));
    directed.push_back(mk(ACT_MINUS, 2 * ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, S_MIN, ONE, ONE, -ONE, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_MINUS, ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    // header in the middle of a face, small neighbour
    directed.push_back(mk(ACT_HEADER, 0, ONE, 0, 0, 0, 4 * ONE, ONE, 2 * ONE, 1, 0, 0));
    directed.push_back(mk(ACT_MINUS, ONE, 3 * ONE, 0, ONE, ONE, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_PLUS, 0, -ONE, 0, 3 * ONE, ONE, 0, 0, 0, 0, 0, 0));

    phase_scale = '{64'h1_0000_0000, 64'd0, 64'h7FFF_FFFF_FFFF, 64'h8000_0000,
                    64'h2_0000_0000, 64'd0, 64'd0};
    phase_order = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd0, 4'd0};
    phase_gauss = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd0};
    phase_scale[5] = {$urandom, $urandom} >> 17;
    phase_order[5] = 4'($urandom);
    phase_scale[6] = 64'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 2);
    phase_order[6] = 4'($urandom_range(0, 4));
    phase_gauss[6] = 5'($urandom_range(1, 16));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_item(directed[i]);

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      write_reg(REG_SCALE, phase_scale[ph]);
      write_reg(REG_ORDER, 64'(phase_order[ph]));
      write_reg(REG_GAUSS, 64'(phase_gauss[ph]));
      idling_on = (ph < 6);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        send_item(header_item());
        counted++;
        n = gauss_count();
        for (int k = 0; k < n; k++) begin
          pick = $urandom_range(0, 39);
          if (pick == 0) begin
            send_item(point_item(ACT_PLUS));
            counted++;
          end else if (pick < 3) begin
            send_item(point_item(ACT_MINUS));
            send_item(point_item(ACT_MINUS));
            send_item(point_item(ACT_PLUS));
            counted += 3;
          end else if (pick < 6) begin
            item_t nz;
            nz = noise_item();
            send_item(nz);
            if (nz.action != ACT_UNUSED) counted++;
          end else begin
            send_item(point_item(ACT_MINUS));
            send_item(point_item(ACT_PLUS));
            counted += 2;
          end
        end
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (expected_flux.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("interior_penalty_face_flux_top_tb passed");
    end else begin
      $display("interior_penalty_face_flux_top_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ipff_pkg.sv
rtl/interior_penalty_face_flux_top.sv
verif/interior_penalty_face_flux_top_tb.sv
